### rtl/sorted_array_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// sorted_array_priority_queue assertion macros
// concurrent checks, empty bodies when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define SPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spq check failed");

// condition must never be true out of reset
`define SPQ_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("spq forbidden condition");

`else

`define SPQ_ASSERT(label, clk, rst_n, prop)
`define SPQ_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants, types and helpers of the sorted array priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // number of keys the queue holds
    localparam int CAPACITY = 16;

    // index into the cell row and width of the stored count
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int ECNT_W   = 5;

    // operation codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // control broadcast to every cell
    typedef struct packed {
        logic                    ins_en;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

    // one result word
    typedef struct packed {
        t_status                 status;
        logic                    max_valid;
        logic signed [KEY_W-1:0] max_key;
        logic [ECNT_W-1:0]       entry_count;
        logic                    is_full;
        logic                    is_empty;
    } t_result;

    // signed key compare
    function automatic logic key_less(
        input logic signed [KEY_W-1:0] a,
        input logic signed [KEY_W-1:0] b
    );
        return a < b;
    endfunction

    // report count on the 5-bit result field, wrapping above 31
    function automatic logic [ECNT_W-1:0] to_entry_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+ECNT_W-1:0] ext;
        ext = {{ECNT_W{1'b0}}, c};
        return ext[ECNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// valid/ready channels carrying command words in and result words out
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic signed [KEY_W-1:0] key_in;

    modport source (output valid, cmd, key_in, input ready);
    modport sink   (input valid, cmd, key_in, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic                    max_valid;
    logic signed [KEY_W-1:0] max_key;
    logic [ECNT_W-1:0]       entry_count;
    logic                    is_full;
    logic                    is_empty;

    modport source (output valid, status, max_valid, max_key, entry_count,
                    is_full, is_empty, input ready);
    modport sink   (input valid, status, max_valid, max_key, entry_count,
                    is_full, is_empty, output ready);
endinterface

`default_nettype wire

### rtl/sorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// max priority queue as an ascending row of key cells with a result register
//
//   channel | dir | word
//   i_in    | in  | cmd, key_in
//   o_out   | out | status, max_valid, max_key, entry_count, is_full, is_empty
//
// one command word per cycle while i_in.ready is high; its result word appears the next cycle
// all cells compare against the new key in parallel and shift together on the accepting edge
// the result register takes a new word on the same edge its held word leaves
// i_in.ready drops only while a result is held and o_out.ready is low
// reset clears the count and the result valid; key cells are not reset
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_array_priority_queue_assert.svh"

module sorted_array_priority_queue import spq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    t_result                 r_res;
    t_result                 n_res;

    t_cell_ctl               w_ctl;
    logic signed [KEY_W-1:0] w_key [CAPACITY];
    logic                    w_lt  [CAPACITY];

    logic                    w_acc;
    logic                    w_ins;
    logic                    w_full;
    logic                    w_empty;
    logic [CNT_W-1:0]        w_cm1;
    logic [CNT_W-1:0]        w_cm2;
    logic signed [KEY_W-1:0] w_top;
    logic signed [KEY_W-1:0] w_second;

    // handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_ins      = (i_in.cmd == CMD_INSERT);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    // top and next-to-top keys
    assign w_cm1    = r_count - CNT_W'(1);
    assign w_cm2    = r_count - CNT_W'(2);
    assign w_top    = w_key[w_cm1[IDX_W-1:0]];
    assign w_second = w_key[w_cm2[IDX_W-1:0]];

    // broadcast to the cell row
    assign w_ctl.ins_en = w_acc && w_ins && !w_full;
    assign w_ctl.key    = i_in.key_in;

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    w_occ;
        logic signed [KEY_W-1:0] w_pkey;
        logic                    w_plt;

        assign w_occ = (CNT_W'(g) < r_count);
        if (g == 0) begin : g_first
            assign w_pkey = i_in.key_in;
            assign w_plt  = 1'b1;
        end else begin : g_rest
            assign w_pkey = w_key[g-1];
            assign w_plt  = w_lt[g-1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (w_occ),
            .i_prev_key (w_pkey),
            .i_prev_lt  (w_plt),
            .o_key      (w_key[g]),
            .o_lt       (w_lt[g])
        );
    end

    // next count and result word
    always_comb begin
        n_count            = r_count;
        n_res.status       = ST_OK;
        n_res.max_key      = w_empty ? '0 : w_top;
        if (w_ins) begin
            if (w_full) begin
                n_res.status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
                if (w_empty || key_less(w_top, i_in.key_in)) begin
                    n_res.max_key = i_in.key_in;
                end
            end
        end else begin
            if (w_empty) begin
                n_res.status = ST_EMPTY;
            end else begin
                n_count       = w_cm1;
                n_res.max_key = (r_count > CNT_W'(1)) ? w_second : '0;
            end
        end
        n_res.max_valid   = (n_count != '0);
        n_res.entry_count = to_entry_count(n_count);
        n_res.is_full     = (n_count == CNT_W'(CAPACITY));
        n_res.is_empty    = (n_count == '0);
    end

    // count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= n_res;
        end
    end

    // output word
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_res.status;
    assign o_out.max_valid   = r_res.max_valid;
    assign o_out.max_key     = r_res.max_key;
    assign o_out.entry_count = r_res.entry_count;
    assign o_out.is_full     = r_res.is_full;
    assign o_out.is_empty    = r_res.is_empty;

    // checks
    `SPQ_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(CAPACITY))
    `SPQ_ASSERT(a_held_blocks, i_clk, i_rst_n, (r_out_valid && !o_out.ready) |-> !i_in.ready)
    `SPQ_ASSERT(a_delete_dec, i_clk, i_rst_n, (w_acc && !w_ins && !w_empty) |=> (r_count == $past(w_cm1)))
    `SPQ_ASSERT(a_flags_agree, i_clk, i_rst_n, r_out_valid |-> (r_res.max_valid != r_res.is_empty))

endmodule

`default_nettype wire

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: holds a key, compares it with the incoming
// key and on insert keeps, takes the new key or takes its lower neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic                    i_occ,
    input  wire logic signed [KEY_W-1:0] i_prev_key,
    input  wire logic                    i_prev_lt,
    output logic signed [KEY_W-1:0]      o_key,
    output logic                         o_lt
);

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    w_lt;

    // stored key below the new one: this slot stays put
    assign w_lt = i_occ && key_less(r_key, i_ctl.key);

    // first slot not below takes the new key, slots above shift up
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins_en && !w_lt) begin
            n_key = i_prev_lt ? i_ctl.key : i_prev_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_lt  = w_lt;

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted array priority queue: a short table of
// directed words, then random insert and delete runs, each result word
// compared field by field against a fixed expected word or a behavioral model of the sorted array
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import spq_pkg::*;

    localparam int RANDOM_WORDS = 900;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SHOW_LIMIT   = 10;

    // one row of the directed table
    typedef struct {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        bit                      fixed;
        t_result                 want;
    } t_plan_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    spq_in_if  cmd_ch ();
    spq_out_if res_ch ();

    sorted_array_priority_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    // shadow copy of the queue contents
    logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
    int                      shadow_count;

    t_result   pending_results [$];
    t_plan_row directed_plan   [$];

    int unsigned cycles;
    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned inserts_done;
    int unsigned deletes_done;
    int unsigned full_rejects;
    int unsigned empty_rejects;
    int          peak_fill;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // apply one command to the shadow queue and return the word it reports
    function automatic t_result track_queue(input logic cmd,
                                            input logic signed [KEY_W-1:0] key);
        t_result r;
        int      slot;
        r.status = ST_OK;
        if (cmd == CMD_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // new key goes in front of the first key that is not smaller
                slot = 0;
                while (slot < shadow_count && shadow_keys[slot] < key)
                    slot++;
                for (int i = shadow_count; i > slot; i--)
                    shadow_keys[i] = shadow_keys[i-1];
                shadow_keys[slot] = key;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            shadow_count--;
        end
        r.max_valid   = (shadow_count != 0);
        r.max_key     = (shadow_count != 0) ? shadow_keys[shadow_count-1] : '0;
        r.entry_count = ECNT_W'(shadow_count);
        r.is_full     = (shadow_count == CAPACITY);
        r.is_empty    = (shadow_count == 0);
        return r;
    endfunction

    function automatic t_result make_result(input t_status st, input logic mv,
                                            input logic signed [KEY_W-1:0] mk,
                                            input int cnt, input logic full,
                                            input logic empty);
        t_result r;
        r.status      = st;
        r.max_valid   = mv;
        r.max_key     = mk;
        r.entry_count = ECNT_W'(cnt);
        r.is_full     = full;
        r.is_empty    = empty;
        return r;
    endfunction

    function automatic void add_row(input logic cmd, input logic signed [KEY_W-1:0] key,
                                    input bit fixed, input t_result want);
        t_plan_row row;
        row.cmd   = cmd;
        row.key   = key;
        row.fixed = fixed;
        row.want  = want;
        directed_plan.push_back(row);
    endfunction

    // wait cycles for one word, none during calm stretches
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    // key mix: full range, a narrow band for duplicates, extremes, a wider band around zero
    function automatic logic signed [KEY_W-1:0] pick_key();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            return $urandom;
        end else if (pick < 65) begin
            v = $urandom_range(0, 8);
            return v - 4;
        end else if (pick < 80) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return '0;
                default: return -1;
            endcase
        end else begin
            v = $urandom_range(0, 2000);
            return v - 1000;
        end
    endfunction

    // offer one word, then record its expected result once accepted
    task automatic send_word(input logic cmd, input logic signed [KEY_W-1:0] key,
                             input int gap, input bit fixed, input t_result want);
        t_result r;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.cmd    <= cmd;
        cmd_ch.key_in <= key;
        do @(posedge i_clk); while (!cmd_ch.ready);
        r = track_queue(cmd, key);
        pending_results.push_back(fixed ? want : r);
        words_sent++;
        if (shadow_count > peak_fill)
            peak_fill = shadow_count;
        case (r.status)
            ST_FULL:  full_rejects++;
            ST_EMPTY: empty_rejects++;
            default: begin
                if (cmd == CMD_INSERT)
                    inserts_done++;
                else
                    deletes_done++;
            end
        endcase
    endtask

    // stimulus and end of run
    initial begin
        int unsigned run_left;
        int unsigned insert_pct;
        logic        cmd;
        t_result     none;
        none          = '0;
        shadow_count  = 0;
        peak_fill     = 0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.cmd    <= CMD_INSERT;
        cmd_ch.key_in <= '0;

        // directed table: empty, extremes, duplicates, fill to full, drain a little
        add_row(CMD_DELETE, 32'sh1234_5678, 1'b1,
                make_result(ST_EMPTY, 1'b0, '0, 0, 1'b0, 1'b1));
        add_row(CMD_INSERT, 32'sh7fff_ffff, 1'b1,
                make_result(ST_OK, 1'b1, 32'sh7fff_ffff, 1, 1'b0, 1'b0));
        add_row(CMD_INSERT, 32'sh8000_0000, 1'b1,
                make_result(ST_OK, 1'b1, 32'sh7fff_ffff, 2, 1'b0, 1'b0));
        add_row(CMD_DELETE, 32'shdead_beef, 1'b1,
                make_result(ST_OK, 1'b1, 32'sh8000_0000, 1, 1'b0, 1'b0));
        add_row(CMD_INSERT, -1, 1'b0, none);
        add_row(CMD_INSERT, 0, 1'b0, none);
        add_row(CMD_INSERT, 0, 1'b0, none);
        add_row(CMD_INSERT, 1, 1'b0, none);
        add_row(CMD_INSERT, 32'sh7fff_ffff, 1'b0, none);
        add_row(CMD_INSERT, 32'sh7fff_ffff, 1'b0, none);
        add_row(CMD_INSERT, 32'sh8000_0000, 1'b0, none);
        add_row(CMD_INSERT, 32'sh5555_5555, 1'b0, none);
        add_row(CMD_INSERT, 32'shaaaa_aaaa, 1'b0, none);
        add_row(CMD_INSERT, 100, 1'b0, none);
        add_row(CMD_INSERT, -100, 1'b0, none);
        add_row(CMD_INSERT, 7, 1'b0, none);
        add_row(CMD_INSERT, 7, 1'b0, none);
        add_row(CMD_INSERT, 32'sh0000_ffff, 1'b0, none);
        add_row(CMD_INSERT, 32'shffff_0000, 1'b0, none);
        add_row(CMD_INSERT, 3, 1'b1,
                make_result(ST_FULL, 1'b1, 32'sh7fff_ffff, CAPACITY, 1'b1, 1'b0));
        add_row(CMD_DELETE, 32'shffff_ffff, 1'b1,
                make_result(ST_OK, 1'b1, 32'sh7fff_ffff, CAPACITY - 1, 1'b0, 1'b0));
        add_row(CMD_DELETE, 0, 1'b0, none);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[n])
            send_word(directed_plan[n].cmd, directed_plan[n].key, draw_wait(1'b0),
                      directed_plan[n].fixed, directed_plan[n].want);

        // random runs, each leaning toward filling, churning or draining
        run_left   = 0;
        insert_pct = 50;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            run_left--;
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
            send_word(cmd, pick_key(), draw_wait(((n / 64) % 3) == 0), 1'b0, none);
        end
        cmd_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d words, %0d inserts, %0d deletes, %0d full and %0d empty rejects",
                 words_sent, inserts_done, deletes_done, full_rejects, empty_rejects);
        $display("tb: peak fill %0d of %0d, %0d results checked, %0d mismatches",
                 peak_fill, CAPACITY, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side: random stalls, calm stretches, one long hold-off
    initial begin
        int          stall;
        int unsigned taken;
        bit          held;
        taken = 0;
        held  = 1'b0;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && taken >= HOLD_AT) begin
                res_ch.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge i_clk);
                held = 1'b1;
            end
            stall = draw_wait(((taken / 50) % 3) == 1);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            taken++;
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.status      = t_status'(res_ch.status);
            got.max_valid   = res_ch.max_valid;
            got.max_key     = res_ch.max_key;
            got.entry_count = res_ch.entry_count;
            got.is_full     = res_ch.is_full;
            got.is_empty    = res_ch.is_empty;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("tb: unexpected result word %0d", results_seen);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.max_valid !== want.max_valid ||
                    got.max_key !== want.max_key || got.entry_count !== want.entry_count ||
                    got.is_full !== want.is_full || got.is_empty !== want.is_empty) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT) begin
                        $display("tb: result %0d want st=%0d mv=%b max=%0d cnt=%0d f=%b e=%b",
                                 results_seen, want.status, want.max_valid, want.max_key,
                                 want.entry_count, want.is_full, want.is_empty);
                        $display("tb: result %0d got  st=%0d mv=%b max=%0d cnt=%0d f=%b e=%b",
                                 results_seen, got.status, got.max_valid, got.max_key,
                                 got.entry_count, got.is_full, got.is_empty);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial cycles = 0;

endmodule

`default_nettype wire

### sorted_array_priority_queue.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_array_priority_queue.sv
tb/tb.sv
